[sv/bbm_pkg.sv]
// Shared types, constants and helpers for the binary boundary marker.
// No dependencies; imported by the core and the testbench.
package bbm_pkg;

  localparam int unsigned MAX_WIDTH_DEF  = 2048;
  localparam int unsigned MAX_HEIGHT_DEF = 4096;
  localparam int unsigned WIDTH_RST      = 640;
  localparam int unsigned HEIGHT_RST     = 480;

  localparam int unsigned PIXEL_W     = 8;
  localparam int unsigned IMG_WIDTH_W = 12;
  localparam int unsigned IMG_HEIGHT_W = 13;
  localparam int unsigned CFG_IDX_W   = 1;
  localparam int unsigned CFG_DATA_W  = 13;
  localparam int unsigned OUT_DATA_W  = 8;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

  localparam int unsigned OFIFO_DEPTH = 8;
  localparam int unsigned OFIFO_AW    = 3;
  localparam int unsigned OFIFO_CW    = 4;

  typedef struct packed {
    logic edge_mark;
    logic run_last;
    logic frame_end;
  } result_t;

  // Last index of a dimension clamped to 1..max.
  function automatic int unsigned clamp_last(int unsigned v, int unsigned max);
    int unsigned r;
    r = v;
    if (v < 1) r = 1;
    if (v > max) r = max;
    return r - 1;
  endfunction

endpackage

[sv/bbm_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module bbm_ram #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 2048,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[sv/binary_boundary_marker_core.sv]
// Results enter the output queue from stage 1 after the completing item is registered there.
// Throughput: one pixel per cycle unless input stalls; the line store is read at accept and
// written in the next cycle; output drains one result per cycle while m_axis_tready is set.
// Row ends push two if width exceeds one; an eight-entry output queue absorbs these, and
// input stalls only while it lacks room for two results each from the staged and a new item.
// Reset clears counters, queue and pipeline, loads width 640, height 480; no line store clear.
module binary_boundary_marker_core
  import bbm_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [PIXEL_W-1:0]    s_axis_tdata,   // [7:0] pixel
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,   // [0] edge_mark, [7:1] zero
  output logic                  m_axis_tlast,
  output logic                  m_axis_tuser    // [0] frame_end
);

  localparam int unsigned CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int unsigned WL_RST = clamp_last(WIDTH_RST, MAX_WIDTH);
  localparam int unsigned HL_RST = clamp_last(HEIGHT_RST, MAX_HEIGHT);

  // configuration
  logic [CW-1:0] wlast_q, wlast_d;
  logic [RW-1:0] hlast_q, hlast_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    wlast_d = wlast_q;
    hlast_d = hlast_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_IMAGE_WIDTH: begin
          wlast_d = CW'(clamp_last(32'(cfg_data_i[IMG_WIDTH_W-1:0]), MAX_WIDTH));
        end
        REG_IMAGE_HEIGHT: begin
          hlast_d = RW'(clamp_last(32'(cfg_data_i[IMG_HEIGHT_W-1:0]), MAX_HEIGHT));
        end
        default: begin
        end
      endcase
    end
  end

  // stage 0: position counters and line read
  logic          accept;
  logic [CW-1:0] col_q, col_d;
  logic [RW-1:0] row_q, row_d;
  logic          last_col0, last_row0;

  assign accept    = s_axis_tvalid & s_axis_tready;
  assign last_col0 = col_q >= wlast_q;
  assign last_row0 = row_q >= hlast_q;

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (accept) begin
      if (last_col0) begin
        col_d = '0;
        row_d = last_row0 ? '0 : row_q + RW'(1);
      end else begin
        col_d = col_q + CW'(1);
      end
    end
  end

  // stage 1 registers
  logic          s1_valid_q;
  logic          s1_inside_q, s1_col0_q, s1_last_col_q, s1_last_row_q, s1_row_nz_q;
  logic [CW-1:0] s1_col_q;
  logic          fwd_q, fwd_d, fwd_data_q;
  logic          left_q, left_d, pend_q, pend_d;
  logic          line_rdata;

  assign fwd_d = accept & s1_valid_q & (s1_col_q == col_q);

  bbm_ram #(
    .WIDTH (1),
    .DEPTH (MAX_WIDTH)
  ) u_line (
    .clk_i   (clk_i),
    .we_i    (s1_valid_q),
    .waddr_i (s1_col_q),
    .wdata_i (s1_inside_q),
    .re_i    (accept),
    .raddr_i (col_q),
    .rdata_o (line_rdata)
  );

  // stage 1: mark and push
  logic    above, left, mark;
  result_t pend_res, last_res;
  logic [1:0] push_n;

  always_comb begin
    above = s1_row_nz_q & (fwd_q ? fwd_data_q : line_rdata);
    left  = s1_col0_q ? 1'b0 : left_q;
    mark  = (s1_inside_q ^ above) | (s1_inside_q & ~left) | (s1_last_row_q & s1_inside_q);
    pend_res.edge_mark = pend_q | (left & ~s1_inside_q);
    pend_res.run_last  = ~s1_last_col_q;
    pend_res.frame_end = 1'b0;
    last_res.edge_mark = mark | s1_inside_q;
    last_res.run_last  = 1'b1;
    last_res.frame_end = s1_last_row_q;
    push_n = '0;
    left_d = left_q;
    pend_d = pend_q;
    if (s1_valid_q) begin
      push_n = {1'b0, ~s1_col0_q} + {1'b0, s1_last_col_q};
      if (s1_last_col_q) begin
        left_d = 1'b0;
        pend_d = 1'b0;
      end else begin
        left_d = s1_inside_q;
        pend_d = mark;
      end
    end
  end

  // output queue
  result_t               fifo_q [OFIFO_DEPTH];
  logic [OFIFO_AW-1:0]   wptr_q, wptr_d, rptr_q, rptr_d;
  logic [OFIFO_CW-1:0]   cnt_q, cnt_d;
  logic                  pop;
  logic [OFIFO_CW:0]     room_need;

  assign m_axis_tvalid = cnt_q != '0;
  assign pop           = m_axis_tvalid & m_axis_tready;
  assign m_axis_tdata  = {{(OUT_DATA_W-1){1'b0}}, fifo_q[rptr_q].edge_mark};
  assign m_axis_tlast  = fifo_q[rptr_q].run_last;
  assign m_axis_tuser  = fifo_q[rptr_q].frame_end;

  assign room_need     = {1'b0, cnt_q} + (s1_valid_q ? (OFIFO_CW+1)'(2) : '0);
  assign s_axis_tready = room_need <= (OFIFO_CW+1)'(OFIFO_DEPTH - 2);

  assign wptr_d = wptr_q + OFIFO_AW'(push_n);
  assign rptr_d = rptr_q + OFIFO_AW'(pop);
  assign cnt_d  = cnt_q + OFIFO_CW'(push_n) - OFIFO_CW'(pop);

  always_ff @(posedge clk_i) begin
    if (push_n != '0) begin
      fifo_q[wptr_q] <= s1_col0_q ? last_res : pend_res;
    end
    if (push_n == 2'd2) begin
      fifo_q[wptr_q + OFIFO_AW'(1)] <= last_res;
    end
    if (accept) begin
      s1_inside_q   <= s_axis_tdata != '0;
      s1_col_q      <= col_q;
      s1_col0_q     <= col_q == '0;
      s1_last_col_q <= last_col0;
      s1_last_row_q <= last_row0;
      s1_row_nz_q   <= row_q != '0;
    end
    fwd_data_q <= s1_inside_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wlast_q    <= WL_RST[CW-1:0];
      hlast_q    <= HL_RST[RW-1:0];
      col_q      <= '0;
      row_q      <= '0;
      s1_valid_q <= 1'b0;
      fwd_q      <= 1'b0;
      left_q     <= 1'b0;
      pend_q     <= 1'b0;
      wptr_q     <= '0;
      rptr_q     <= '0;
      cnt_q      <= '0;
    end else begin
      wlast_q    <= wlast_d;
      hlast_q    <= hlast_d;
      col_q      <= col_d;
      row_q      <= row_d;
      s1_valid_q <= accept;
      fwd_q      <= fwd_d;
      left_q     <= left_d;
      pend_q     <= pend_d;
      wptr_q     <= wptr_d;
      rptr_q     <= rptr_d;
      cnt_q      <= cnt_d;
    end
  end

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q |-> ({1'b0, cnt_q} + (OFIFO_CW+1)'(2)) <= (OFIFO_CW+1)'(OFIFO_DEPTH))
    else $error("output queue overflow");
  a_stage_adv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> s1_valid_q)
    else $error("accepted item did not reach stage 1");
  a_fwd_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fwd_q |-> s1_valid_q)
    else $error("forward without item in stage 1");
`endif

endmodule

[test/tb.sv]
// Testbench for binary_boundary_marker_core: random and directed binary images,
// with a per-pixel boundary predictor checked against the output stream.
// Depends on bbm_pkg and the core RTL only.
module tb;
  import bbm_pkg::*;

  localparam int unsigned STALL_LIMIT = 5000;
  localparam int unsigned LINE_DEPTH  = MAX_WIDTH_DEF;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  cfg_valid_i   = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i   = REG_IMAGE_WIDTH;
  logic [CFG_DATA_W-1:0] cfg_data_i    = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [PIXEL_W-1:0]    s_axis_tdata  = '0;   // [7:0] pixel
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;         // [0] edge_mark, [7:1] zero
  logic                  m_axis_tlast;
  logic                  m_axis_tuser;         // [0] frame_end

  binary_boundary_marker_core i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #5 clk_i = ~clk_i;

  // Boundary predictor state
  logic [11:0]  img_w = 12'(WIDTH_RST);
  logic [12:0]  img_h = 13'(HEIGHT_RST);
  logic         line_inside [LINE_DEPTH];
  logic         line_filled [LINE_DEPTH];
  logic         left_in   = 1'b0;
  logic         pend_mark = 1'b0;
  int unsigned  col_pos   = 0;
  int unsigned  row_pos   = 0;

  logic [PIXEL_W-1:0] pending_pixels [$];
  result_t            expected_marks [$];

  int          err_count   = 0;
  int unsigned idle_cycles = 0;
  bit          px_taken    = 1'b0;
  int          tx_gap      = 0;
  int          tx_burst    = 0;
  bit          hold_armed  = 1'b0;
  int          hold_left   = 0;
  int          rx_mode     = 0;
  int          rx_left     = 0;
  result_t     want;

  initial begin
    for (int i = 0; i < LINE_DEPTH; i++) begin
      line_inside[i] = 1'b0;
      line_filled[i] = 1'b0;
    end
  end

  function automatic void queue_pixel(input logic [PIXEL_W-1:0] px);
    pending_pixels = {pending_pixels, px};
  endfunction

  function automatic void queue_result(input result_t res);
    expected_marks = {expected_marks, res};
  endfunction

  function automatic int unsigned clamp_to(int unsigned v, int unsigned hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic int unsigned eff_width();
    return clamp_to(img_w, MAX_WIDTH_DEF);
  endfunction

  function automatic int unsigned eff_height();
    return clamp_to(img_h, MAX_HEIGHT_DEF);
  endfunction

  function automatic int unsigned line_prefix();
    int unsigned n;
    n = 0;
    while (n < LINE_DEPTH && line_filled[n]) n++;
    return n;
  endfunction

  function automatic int unsigned items_to_frame_end();
    int unsigned w, h, rows_left, cols_left;
    w = eff_width();
    h = eff_height();
    rows_left = (row_pos + 1 >= h) ? 1 : h - row_pos;
    cols_left = (col_pos + 1 >= w) ? 1 : w - col_pos;
    return (rows_left - 1) * w + cols_left;
  endfunction

  function automatic void predict_boundary(input logic [PIXEL_W-1:0] px);
    int unsigned w, h;
    logic px_in, above, left, mark, last_col, last_row;
    result_t r;
    w = eff_width();
    h = eff_height();
    px_in    = |px;
    last_col = (col_pos + 1 >= w);
    last_row = (row_pos + 1 >= h);
    above    = (row_pos != 0 && col_pos < LINE_DEPTH) ? line_inside[col_pos] : 1'b0;
    left     = (col_pos == 0) ? 1'b0 : left_in;
    mark     = (px_in ^ above) | (px_in & ~left);
    if (last_row) mark = mark | px_in;
    if (col_pos != 0) begin
      r.edge_mark = pend_mark | (left & ~px_in);
      r.run_last  = ~last_col;
      r.frame_end = 1'b0;
      queue_result(r);
    end
    if (col_pos < LINE_DEPTH) begin
      line_inside[col_pos] = px_in;
      line_filled[col_pos] = 1'b1;
    end
    if (last_col) begin
      r.edge_mark = mark | px_in;
      r.run_last  = 1'b1;
      r.frame_end = last_row;
      queue_result(r);
      col_pos   = 0;
      row_pos   = last_row ? 0 : row_pos + 1;
      pend_mark = 1'b0;
      left_in   = 1'b0;
    end else begin
      pend_mark = mark;
      left_in   = px_in;
      col_pos   = col_pos + 1;
    end
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    err_count++;
  endtask

  // Sender: bursts with random gaps
  always @(negedge clk_i) begin
    if (!(s_axis_tvalid && !px_taken)) begin
      px_taken = 1'b0;
      if (tx_gap > 0) begin
        tx_gap--;
        s_axis_tvalid <= 1'b0;
      end else if (pending_pixels.size() != 0) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= pending_pixels[0];
        if (tx_burst > 0) begin
          tx_burst--;
        end else begin
          tx_burst = $urandom_range(1, 40);
          tx_gap   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
        end
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      predict_boundary(s_axis_tdata);
      void'(pending_pixels.pop_front());
      px_taken = 1'b1;
    end
  end

  // Receiver: stall pattern in modes, plus a long hold-off on request
  always @(negedge clk_i) begin
    if (hold_armed) begin
      hold_left  = 300;
      hold_armed = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      if (rx_left == 0) begin
        rx_mode = $urandom_range(0, 2);
        rx_left = $urandom_range(16, 128);
      end
      rx_left--;
      case (rx_mode)
        0: m_axis_tready <= 1'b1;
        1: m_axis_tready <= 1'($urandom_range(0, 1));
        default: m_axis_tready <= ($urandom_range(0, 4) != 0);
      endcase
    end
  end

  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) begin
      if (expected_marks.size() == 0) begin
        report_mismatch("result with nothing expected");
      end else begin
        want = expected_marks.pop_front();
        if (m_axis_tdata != {7'b0, want.edge_mark})
          report_mismatch($sformatf("tdata %h, want edge_mark %b", m_axis_tdata, want.edge_mark));
        if (m_axis_tlast != want.run_last)
          report_mismatch($sformatf("tlast %b, want %b", m_axis_tlast, want.run_last));
        if (m_axis_tuser != want.frame_end)
          report_mismatch($sformatf("tuser %b, want %b", m_axis_tuser, want.frame_end));
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    if (idx == REG_IMAGE_WIDTH) img_w = val[11:0];
    else img_h = val;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic push_run(input int unsigned n, input int unsigned density);
    bit px_in;
    px_in = 1'b0;
    for (int unsigned i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) < 4) px_in = ($urandom_range(0, 99) < density);
      queue_pixel(px_in ? 8'($urandom_range(1, 255)) : 8'd0);
    end
  endtask

  task automatic wait_until_drained();
    while (pending_pixels.size() != 0 || expected_marks.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  initial begin
    int unsigned rand_items, phase, n, sel, density;
    logic [11:0] wv;
    logic [12:0] hv;
    rand_items = 0;
    phase      = 0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // part of a row at the reset geometry, then shrink mid-frame
    queue_pixel(8'd0);
    queue_pixel(8'd255);
    queue_pixel(8'd1);
    queue_pixel(8'd128);
    queue_pixel(8'd0);
    wait_until_drained();
    write_reg(REG_IMAGE_WIDTH, 13'h1003);
    write_reg(REG_IMAGE_HEIGHT, 13'd2);
    queue_pixel(8'd64);
    queue_pixel(8'd0);
    queue_pixel(8'd2);
    queue_pixel(8'd4);
    wait_until_drained();

    // zero width and height act as one pixel per frame
    write_reg(REG_IMAGE_WIDTH, 13'd0);
    write_reg(REG_IMAGE_HEIGHT, 13'd0);
    queue_pixel(8'd0);
    queue_pixel(8'd255);
    queue_pixel(8'd16);
    queue_pixel(8'd0);
    queue_pixel(8'd32);
    wait_until_drained();

    // clamped geometry, then a mid-row shrink to single-pixel rows
    write_reg(REG_IMAGE_WIDTH, 13'd4095);
    write_reg(REG_IMAGE_HEIGHT, 13'd8191);
    push_run(64, 50);
    wait_until_drained();
    write_reg(REG_IMAGE_WIDTH, 13'd1);
    push_run(16, 50);
    wait_until_drained();

    while (rand_items < 640) begin
      phase++;
      sel = $urandom_range(0, 3);
      if (sel[0]) begin
        case ($urandom_range(0, 9))
          0: wv = 12'd0;
          1: wv = 12'($urandom_range(2049, 4095));
          default: wv = 12'($urandom_range(1, 16));
        endcase
        if (row_pos != 0 && clamp_to(wv, MAX_WIDTH_DEF) > line_prefix())
          wv = 12'($urandom_range(1, line_prefix()));
        write_reg(REG_IMAGE_WIDTH, {1'($urandom_range(0, 1)), wv});
      end
      if (sel[1]) begin
        case ($urandom_range(0, 9))
          0: hv = 13'd0;
          1: hv = 13'($urandom_range(4097, 8191));
          default: hv = 13'($urandom_range(1, 8));
        endcase
        write_reg(REG_IMAGE_HEIGHT, hv);
      end
      case ($urandom_range(0, 4))
        0: density = 0;
        1: density = 100;
        default: density = $urandom_range(10, 90);
      endcase
      if ($urandom_range(0, 1) == 1 && items_to_frame_end() <= 200)
        n = items_to_frame_end();
      else
        n = $urandom_range(1, 60);
      if (phase == 4) begin
        hold_armed = 1'b1;
        n = 150;
      end
      push_run(n, density);
      rand_items += n;
      wait_until_drained();
    end

    if (err_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
